// File: hdl/pcp_pkg.sv
`default_nettype none
package pcp_pkg;

  localparam int unsigned MOD_Q       = 3329;
  localparam int unsigned HALF_Q      = 1664;
  localparam int unsigned RECIP_MUL   = 20159;
  localparam int unsigned RECIP_SHIFT = 26;
  // Ten times q less 32768, added to x + 32768 after the sign flip, keeps x + 10q positive.
  localparam int unsigned BIAS_ADD    = 522;

  localparam int unsigned COEFF_W = 16;
  localparam int unsigned BIASED_W = 17;
  localparam int unsigned PROD1_W = 32;
  localparam int unsigned RESID_W = 12;
  localparam int unsigned SCALED_W = 23;
  localparam int unsigned PROD2_W = 38;
  localparam int unsigned CMP_W = 11;
  localparam int unsigned ACC_W = 24;
  localparam int unsigned LEFT_W = 7;
  localparam int unsigned LCNT_W = 3;

  typedef enum logic [1:0] {
    MODE_4  = 2'd0,
    MODE_5  = 2'd1,
    MODE_10 = 2'd2,
    MODE_11 = 2'd3
  } mode_e;

  typedef struct packed {
    logic load;
    logic reduce;
    logic scale;
    logic pack;
  } ctrl_cmd_t;

  typedef struct packed {
    logic room;
  } ctrl_status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  function automatic logic [3:0] width_of_mode(input mode_e mode);
    logic [3:0] w;
    case (mode)
      MODE_4:  w = 4'd4;
      MODE_5:  w = 4'd5;
      MODE_10: w = 4'd10;
      MODE_11: w = 4'd11;
      default: w = 4'd10;
    endcase
    return w;
  endfunction

  function automatic logic [CMP_W-1:0] mask_of_mode(input mode_e mode);
    logic [CMP_W-1:0] m;
    case (mode)
      MODE_4:  m = 11'h00F;
      MODE_5:  m = 11'h01F;
      MODE_10: m = 11'h3FF;
      MODE_11: m = 11'h7FF;
      default: m = 11'h3FF;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// File: hdl/pcp_coeff_if.sv
`default_nettype none
interface pcp_coeff_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coeff;

  modport source (output valid, output coeff, input ready);
  modport sink (input valid, input coeff, output ready);
endinterface
`default_nettype wire

// File: hdl/pcp_byte_if.sv
`default_nettype none
interface pcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       last;

  modport source (output valid, output packed_byte, output last, input ready);
  modport sink (input valid, input packed_byte, input last, output ready);
endinterface
`default_nettype wire

// File: hdl/pcp_out_fifo.sv
`default_nettype none
module pcp_out_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [1:0]            push_cnt_i,
  input  wire pcp_pkg::out_beat_t push0_i,
  input  wire pcp_pkg::out_beat_t push1_i,
  output pcp_pkg::ctrl_status_t status_o,
  output logic                 valid_o,
  input  wire                  ready_i,
  output pcp_pkg::out_beat_t   beat_o
);

  pcp_pkg::out_beat_t mem_q [4];
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 3'd0);
  assign pop     = valid_o && ready_i;
  assign beat_o  = mem_q[rd_ptr_q];
  // A coefficient may produce two bytes, so the packer waits for two free slots.
  assign status_o.room = (count_q <= 3'd2);

  always_comb begin
    rd_ptr_d = rd_ptr_q + 2'(pop);
    wr_ptr_d = wr_ptr_q + push_cnt_i;
    count_d  = count_q + 3'(push_cnt_i) - 3'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= push1_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4) else $error("output queue count beyond its depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> status_o.room) else $error("bytes pushed without room");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 3'd1 && pop && push_cnt_i == 2'd0) |=> !valid_o)
    else $error("queue still valid after its last byte left");

endmodule
`default_nettype wire

// File: hdl/pcp_ctrl.sv
`default_nettype none
module pcp_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire pcp_pkg::ctrl_status_t status_i,
  output pcp_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RED   = 4'b0010,
    ST_SCALE = 4'b0100,
    ST_PACK  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RED;
        end
      end
      ST_RED: begin
        cmd_o.reduce = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_PACK;
      end
      ST_PACK: begin
        if (status_i.room) begin
          cmd_o.pack = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/pcp_datapath.sv
`default_nettype none
module pcp_datapath #(
  parameter int unsigned COEFF_COUNT = 256,
  parameter int unsigned IDX_W = 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 mode_we_i,
  input  wire [1:0]           mode_wdata_i,
  input  wire signed [15:0]   coeff_i,
  input  wire pcp_pkg::ctrl_cmd_t cmd_i,
  output logic [1:0]          push_cnt_o,
  output pcp_pkg::out_beat_t  push0_o,
  output pcp_pkg::out_beat_t  push1_o
);

  pcp_pkg::mode_e mode_q;

  logic [pcp_pkg::BIASED_W-1:0] biased;
  logic [pcp_pkg::BIASED_W-1:0] biased_q;
  logic [pcp_pkg::PROD1_W-1:0]  prod1_q;
  logic [4:0]                   quot;
  logic [pcp_pkg::BIASED_W-1:0] rem_raw;
  logic [pcp_pkg::RESID_W-1:0]  resid_d, resid_q;
  logic [pcp_pkg::SCALED_W-1:0] scaled;
  logic [pcp_pkg::PROD2_W-1:0]  prod2_q;

  logic [pcp_pkg::LEFT_W-1:0] left_q, left_d;
  logic [pcp_pkg::LCNT_W-1:0] lcnt_q, lcnt_d;
  logic [IDX_W-1:0]           idx_q, idx_d;

  logic [pcp_pkg::CMP_W-1:0] comp;
  logic [pcp_pkg::ACC_W-1:0] acc, acc_shift;
  logic [4:0]                nbits;
  logic [1:0]                full_bytes, emit_cnt;
  logic                      final_coeff;

  // Flipping the sign bit gives x + 32768; the bias brings it to x + 10q.
  assign biased = {1'b0, coeff_i ^ 16'h8000} + 17'(pcp_pkg::BIAS_ADD);

  // The reciprocal estimate never overshoots, so at most one subtraction fixes it.
  always_comb begin
    quot    = prod1_q[pcp_pkg::RECIP_SHIFT +: 5];
    rem_raw = biased_q - 17'(quot * 12'(pcp_pkg::MOD_Q));
    if (rem_raw >= 17'(pcp_pkg::MOD_Q)) begin
      resid_d = 12'(rem_raw - 17'(pcp_pkg::MOD_Q));
    end else begin
      resid_d = 12'(rem_raw);
    end
  end

  assign scaled = (23'(resid_q) << pcp_pkg::width_of_mode(mode_q))
                  + 23'(pcp_pkg::HALF_Q);

  always_comb begin
    comp = prod2_q[pcp_pkg::RECIP_SHIFT +: pcp_pkg::CMP_W] & pcp_pkg::mask_of_mode(mode_q);
    acc  = 24'(left_q) | (24'(comp) << lcnt_q);
    nbits = 5'(lcnt_q) + 5'(pcp_pkg::width_of_mode(mode_q));
    if (nbits[4]) begin
      full_bytes = 2'd2;
    end else if (nbits[3]) begin
      full_bytes = 2'd1;
    end else begin
      full_bytes = 2'd0;
    end
    final_coeff = (idx_q == IDX_W'(COEFF_COUNT - 1));
    // On the final coefficient a partial byte is padded with zeros and sent, unless two full bytes already go.
    if (final_coeff && (nbits[2:0] != 3'd0) && (full_bytes != 2'd2)) begin
      emit_cnt = full_bytes + 2'd1;
    end else begin
      emit_cnt = full_bytes;
    end
    acc_shift = acc >> {full_bytes, 3'b000};

    push_cnt_o   = cmd_i.pack ? emit_cnt : 2'd0;
    push0_o.data = acc[7:0];
    push0_o.last = final_coeff && (emit_cnt == 2'd1);
    push1_o.data = acc[15:8];
    push1_o.last = final_coeff;

    if (final_coeff) begin
      left_d = '0;
      lcnt_d = '0;
      idx_d  = '0;
    end else begin
      left_d = acc_shift[pcp_pkg::LEFT_W-1:0];
      lcnt_d = nbits[2:0];
      idx_d  = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      biased_q <= biased;
      prod1_q  <= 32'(biased) * 32'(pcp_pkg::RECIP_MUL);
    end
    if (cmd_i.reduce) begin
      resid_q <= resid_d;
    end
    if (cmd_i.scale) begin
      prod2_q <= 38'(scaled) * 38'(pcp_pkg::RECIP_MUL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pcp_pkg::MODE_10;
      left_q <= '0;
      lcnt_q <= '0;
      idx_q  <= '0;
    end else begin
      if (mode_we_i) begin
        mode_q <= pcp_pkg::mode_e'(mode_wdata_i);
      end
      if (cmd_i.pack) begin
        left_q <= left_d;
        lcnt_q <= lcnt_d;
        idx_q  <= idx_d;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/poly_compress_pack_top.sv
// The controller accepts a coefficient only while idle, then walks it through the two
// reciprocal multiplies (reduction mod q, then compression) and the pack step, whose
// bytes enter the output queue; the next coefficient is taken only after the pack step.
// Up to four bytes queue at the output; the packer stalls while fewer than two slots are free.
// Reset (rst_ni low, asynchronous) empties the queue, clears the carried bits and the
// coefficient index, and sets the width mode to 10 bits.
`default_nettype none
module poly_compress_pack_top #(
  parameter int unsigned COEFF_COUNT = 256
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        bits_mode_we_i,
  input  wire [1:0]  bits_mode_wdata_i,
  pcp_coeff_if.sink  coeff_in_i,
  pcp_byte_if.source byte_out_o
);

  localparam int unsigned IdxW = $clog2(COEFF_COUNT);

  pcp_pkg::ctrl_cmd_t    cmd;
  pcp_pkg::ctrl_status_t status;
  pcp_pkg::out_beat_t    push0, push1, beat;
  logic [1:0]            push_cnt;

  pcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (coeff_in_i.valid),
    .in_ready_o (coeff_in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcp_datapath #(
    .COEFF_COUNT (COEFF_COUNT),
    .IDX_W       (IdxW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_we_i    (bits_mode_we_i),
    .mode_wdata_i (bits_mode_wdata_i),
    .coeff_i      (coeff_in_i.coeff),
    .cmd_i        (cmd),
    .push_cnt_o   (push_cnt),
    .push0_o      (push0),
    .push1_o      (push1)
  );

  pcp_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (push0),
    .push1_i    (push1),
    .status_o   (status),
    .valid_o    (byte_out_o.valid),
    .ready_i    (byte_out_o.ready),
    .beat_o     (beat)
  );

  assign byte_out_o.packed_byte = beat.data;
  assign byte_out_o.last        = beat.last;

endmodule
`default_nettype wire
